// ----- sv/epc_pkg.sv -----
// Shared types and constants for the epoch seconds to calendar converter.
// Used by epc_ctrl, epc_dp and epoch_seconds_to_calendar; no dependencies.
package epc_pkg;

	localparam logic [31:0] LAST_VALID_SEC = 32'd4102444799;
	localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
	localparam logic [16:0] DAYS_PER_BLOCK = 17'd1461;
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN   = 17'd60;
	localparam logic [15:0] DAYS_1968_TO_70 = 16'd731;
	localparam logic [7:0]  BASE_YEAR      = 8'd68;
	localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
	localparam logic [8:0]  DAYS_YEAR      = 9'd365;
	localparam logic [1:0]  LAST_YEAR_IN_BLOCK = 2'd3;
	localparam logic [3:0]  LAST_MONTH     = 4'd11;
	localparam logic [3:0]  FEBRUARY       = 4'd1;

	// reciprocals of the odd parts of the divisors, used after the power-of-two
	// factor is shifted out: 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2
	localparam logic [25:0] RECIP_DAY   = 26'd50903317;  // 2^35 / 675, rounded up
	localparam logic [16:0] RECIP_BLOCK = 17'd91868;     // 2^27 / 1461, rounded up
	localparam logic [13:0] RECIP_HOUR  = 14'd9321;      // 2^21 / 225, rounded up
	localparam logic [10:0] RECIP_MIN   = 11'd1093;      // 2^14 / 15, rounded up

	localparam int TDATA_W = 40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_SAVE_DAY,
		ST_DIV_BLK,
		ST_SAVE_BLK,
		ST_YEAR,
		ST_MONTH,
		ST_LOAD_SOD,
		ST_DIV_HOUR,
		ST_SAVE_HOUR,
		ST_DIV_MIN,
		ST_DONE
	} epc_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_STEP,
		OP_SAVE_DAYS,
		OP_SAVE_BLK,
		OP_YEAR_STEP,
		OP_MONTH_STEP,
		OP_LOAD_SOD,
		OP_SAVE_HOUR,
		OP_FINISH
	} epc_op_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_BLOCK,
		DIV_HOUR,
		DIV_MIN
	} epc_div_t;

	typedef struct packed {
		epc_op_t    op;
		epc_div_t   div;
	} epc_cmd_t;

	typedef struct packed {
		logic oor;
		logic year_stop;
		logic month_stop;
		logic out_busy;
	} epc_stat_t;

	function automatic logic [4:0] month_len_f(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			FEBRUARY: len = leap ? 5'd29 : 5'd28;
			4'd3,
			4'd5,
			4'd8,
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/epc_ctrl.sv -----
// Sequencer for the calendar converter: walks the divider phases and the
// year and month walks, issuing one datapath command per cycle. Uses epc_pkg.
module epc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  epc_pkg::epc_stat_t stat,
	output epc_pkg::epc_cmd_t  cmd
);
	import epc_pkg::*;

	epc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV_DAY;
			end
			ST_DIV_DAY: begin
				if (stat.oor) state_d = ST_DONE;
				else state_d = ST_SAVE_DAY;
			end
			ST_SAVE_DAY:  state_d = ST_DIV_BLK;
			ST_DIV_BLK:   state_d = ST_SAVE_BLK;
			ST_SAVE_BLK:  state_d = ST_YEAR;
			ST_YEAR: begin
				if (stat.year_stop) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				if (stat.month_stop) state_d = ST_LOAD_SOD;
			end
			ST_LOAD_SOD:  state_d = ST_DIV_HOUR;
			ST_DIV_HOUR:  state_d = ST_SAVE_HOUR;
			ST_SAVE_HOUR: state_d = ST_DIV_MIN;
			ST_DIV_MIN:   state_d = ST_DONE;
			ST_DONE: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands; div also picks the divisor for the remainder in the save steps
	always_comb begin
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.div     = DIV_DAY;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_DIV_DAY: begin
				if (!stat.oor) cmd.op = OP_DIV_STEP;
			end
			ST_SAVE_DAY: cmd.op = OP_SAVE_DAYS;
			ST_DIV_BLK: begin
				cmd.op  = OP_DIV_STEP;
				cmd.div = DIV_BLOCK;
			end
			ST_SAVE_BLK: begin
				cmd.op  = OP_SAVE_BLK;
				cmd.div = DIV_BLOCK;
			end
			ST_YEAR:      cmd.op = OP_YEAR_STEP;
			ST_MONTH:     cmd.op = OP_MONTH_STEP;
			ST_LOAD_SOD:  cmd.op = OP_LOAD_SOD;
			ST_DIV_HOUR: begin
				cmd.op  = OP_DIV_STEP;
				cmd.div = DIV_HOUR;
			end
			ST_SAVE_HOUR: begin
				cmd.op  = OP_SAVE_HOUR;
				cmd.div = DIV_HOUR;
			end
			ST_DIV_MIN: begin
				cmd.op  = OP_DIV_STEP;
				cmd.div = DIV_MIN;
			end
			ST_DONE: begin
				cmd.op  = OP_FINISH;
				cmd.div = DIV_MIN;
			end
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule

// ----- sv/epc_dp.sv -----
// Datapath of the calendar converter: shared reciprocal-multiply divider for
// the constant divisors, year and month walk, output register. Uses epc_pkg.
module epc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [31:0]                 in_secs,
	input  epc_pkg::epc_cmd_t           cmd,
	output epc_pkg::epc_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [epc_pkg::TDATA_W-1:0] out_data,
	output logic                        out_user
);
	import epc_pkg::*;

	logic [31:0] rem_q;
	logic [15:0] quo_q;
	logic [16:0] sod_q;
	logic [1:0]  yib_q;
	logic [3:0]  mon_q;
	logic [7:0]  year_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic        oor_q;
	logic        out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic        out_user_q;

	logic [16:0] div_d;
	logic [24:0] mul_a;
	logic [25:0] mul_b;
	logic [50:0] mul_p;
	logic [15:0] quo_d;
	logic [32:0] back_prod;
	logic [31:0] rem_new;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic        year_stop;
	logic        month_stop;
	logic        out_load;
	logic [7:0]  year_fin;
	logic [TDATA_W-1:0] packed_res;

	// operand has the divisor's power-of-two factor shifted out; the rounded-up
	// reciprocal gives the exact quotient over each phase's operand range
	always_comb begin
		unique case (cmd.div)
			DIV_DAY: begin
				div_d = SECS_PER_DAY;
				mul_a = rem_q[31:7];
				mul_b = RECIP_DAY;
			end
			DIV_BLOCK: begin
				div_d = DAYS_PER_BLOCK;
				mul_a = {9'd0, rem_q[15:0]};
				mul_b = {9'd0, RECIP_BLOCK};
			end
			DIV_HOUR: begin
				div_d = SECS_PER_HOUR;
				mul_a = {12'd0, rem_q[16:4]};
				mul_b = {12'd0, RECIP_HOUR};
			end
			DIV_MIN: begin
				div_d = SECS_PER_MIN;
				mul_a = {15'd0, rem_q[11:2]};
				mul_b = {15'd0, RECIP_MIN};
			end
			default: begin
				div_d = SECS_PER_DAY;
				mul_a = rem_q[31:7];
				mul_b = RECIP_DAY;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		unique case (cmd.div)
			DIV_DAY:   quo_d = mul_p[50:35];
			DIV_BLOCK: quo_d = {10'd0, mul_p[32:27]};
			DIV_HOUR:  quo_d = {10'd0, mul_p[26:21]};
			DIV_MIN:   quo_d = {10'd0, mul_p[19:14]};
			default:   quo_d = mul_p[50:35];
		endcase
	end

	// remainder from the registered quotient
	assign back_prod = quo_q * div_d;
	assign rem_new   = rem_q - back_prod[31:0];

	// day-in-block is below 1461 once the block split is done
	assign ylen       = (yib_q == 2'd0) ? DAYS_LEAP_YEAR : DAYS_YEAR;
	assign year_stop  = (yib_q == LAST_YEAR_IN_BLOCK) || (rem_q[10:0] < {2'b0, ylen});
	assign mlen       = month_len_f(mon_q, yib_q == 2'd0);
	assign month_stop = (mon_q == LAST_MONTH) || (rem_q[10:0] < {6'b0, mlen});

	assign out_load = (cmd.op == OP_FINISH) && (!out_valid_q || out_ready);
	assign year_fin = year_q + {6'd0, yib_q};
	// word: year, month, day, hour, minute, second from bit 0 up
	assign packed_res = {6'd0, rem_new[5:0], quo_q[5:0], hour_q, day_q, mon_q, year_fin};

	assign stat.oor        = oor_q;
	assign stat.year_stop  = year_stop;
	assign stat.month_stop = month_stop;
	assign stat.out_busy   = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rem_q <= in_secs;
				quo_q <= '0;
				oor_q <= in_secs > LAST_VALID_SEC;
				yib_q <= '0;
				mon_q <= '0;
			end
			OP_DIV_STEP: begin
				quo_q <= quo_d;
			end
			OP_SAVE_DAYS: begin
				sod_q <= rem_new[16:0];
				rem_q <= {16'd0, quo_q + DAYS_1968_TO_70};
				quo_q <= '0;
			end
			OP_SAVE_BLK: begin
				year_q <= BASE_YEAR + {quo_q[5:0], 2'b00};
				rem_q  <= rem_new;
				quo_q  <= '0;
			end
			OP_YEAR_STEP: begin
				if (!year_stop) begin
					rem_q <= rem_q - {23'd0, ylen};
					yib_q <= yib_q + 2'd1;
				end
			end
			OP_MONTH_STEP: begin
				if (!month_stop) begin
					rem_q <= rem_q - {27'd0, mlen};
					mon_q <= mon_q + 4'd1;
				end
			end
			OP_LOAD_SOD: begin
				day_q <= rem_q[4:0] + 5'd1;
				rem_q <= {15'd0, sod_q};
				quo_q <= '0;
			end
			OP_SAVE_HOUR: begin
				hour_q <= quo_q[4:0];
				rem_q  <= rem_new;
				quo_q  <= '0;
			end
			OP_NONE, OP_FINISH: ;
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= oor_q ? '0 : packed_res;
			out_user_q <= oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// ----- sv/epoch_seconds_to_calendar.sv -----
// Top level of the epoch seconds to calendar converter.
// Instantiates epc_ctrl and epc_dp; uses epc_pkg.
//
// Input stream: s_tdata carries a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00 UTC. Output stream: m_tdata carries the calendar date
// and time of day, m_tuser flags an input after 2099-12-31 23:59:59 (all
// fields of m_tdata are then zero). One output word per input word, in order.
// One word is worked on at a time. s_tready is high only while idle.
// An in-range word goes from acceptance to m_tvalid through these steps in
// order: day quotient and remainder, four-year block quotient and remainder,
// year walk, month walk, load of the second of the day, hour quotient and
// remainder, minute quotient, output load; quotients by reciprocal multiply.
// An out-of-range word goes from the day quotient step straight to the output
// load. The next word is accepted only once the sequencer is back in idle.
// A stalled receiver holds the result in the output register; the block
// finishes the next word and then waits until the held word is taken.
// Reset clears the sequencer and the output valid; no clearing pass.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
	// [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute,
	// [39:34] zero
	output logic [39:0] m_tdata,
	output logic        m_tuser   // [0] out_of_range
);
	import epc_pkg::*;

	epc_cmd_t  cmd;
	epc_stat_t stat;

	epc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	epc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_secs   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

// ----- verif/epoch_seconds_to_calendar_test.sv -----
// Self-checking testbench for epoch_seconds_to_calendar: streams second counts in,
// predicts each calendar word and compares it field by field as it comes out.
// Depends on epc_pkg and the epoch_seconds_to_calendar RTL.
module epoch_seconds_to_calendar_test;
	import epc_pkg::*;

	typedef struct packed {
		logic       oor;
		logic [5:0] pad;
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] mday;
		logic [3:0] mon;
		logic [7:0] year;
	} calendar_t;

	typedef struct {
		logic [31:0] secs;
		int          gap;
		bit          drain;
	} stamp_t;

	localparam int LONG_HOLD_AT     = 450;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LAST_DAY         = 47481;  // day index of 2099-12-31

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	stamp_t    stamp_q[$];
	calendar_t calendar_q[$];
	int        gap_left = 0;
	int        ready_wait = 0;
	int        words_out = 0;
	int        errors = 0;

	epoch_seconds_to_calendar dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Date and time of day for a second count; days rebased to 1968 so each
	// four-year block starts with its leap year.
	function automatic calendar_t calendar_of(input logic [31:0] secs);
		calendar_t   c;
		logic [31:0] sod;
		logic [31:0] days;
		int          yib;
		int          mon;
		int          mlen;
		c = '0;
		if (secs > LAST_VALID_SEC) begin
			c.oor = 1'b1;
			return c;
		end
		sod  = secs % 32'd86400;
		days = secs / 32'd86400 + 32'd731;
		c.year = 8'd68 + 8'(4 * (days / 32'd1461));
		days = days % 32'd1461;
		yib = 0;
		while (yib < 3 && days >= ((yib == 0) ? 32'd366 : 32'd365)) begin
			days -= (yib == 0) ? 32'd366 : 32'd365;
			yib++;
		end
		c.year += 8'(yib);
		mon = 0;
		mlen = 31;
		while (mon < 11) begin
			if (mon == 1)
				mlen = (yib == 0) ? 29 : 28;
			else if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
				mlen = 30;
			else
				mlen = 31;
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		c.mon  = 4'(mon);
		c.mday = 5'(days + 1);
		c.hour = 5'(sod / 3600);
		c.min  = 6'((sod / 60) % 60);
		c.sec  = 6'(sod % 60);
		return c;
	endfunction

	task automatic add_stamp(input logic [31:0] secs, input bit drain);
		stamp_t st;
		st.secs  = secs;
		st.drain = drain;
		// every third block of 100 words goes with no sender gaps
		if ((stamp_q.size() / 100) % 3 == 2)
			st.gap = 0;
		else
			st.gap = $urandom_range(0, 4);
		stamp_q.push_back(st);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				calendar_q.push_back(calendar_of(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (stamp_q.size() > 0 &&
						!(stamp_q[0].drain && calendar_q.size() != 0)) begin
					s_tdata  <= stamp_q[0].secs;
					gap_left <= stamp_q[0].gap;
					s_tvalid <= 1'b1;
					void'(stamp_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : rx_side
		calendar_t want;
		calendar_t got;
		int        n;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (calendar_q.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
			end else begin
				want = calendar_q.pop_front();
				if (got.year !== want.year) begin
					$error("years_since_1900: expected %0d got %0d", want.year, got.year);
					errors++;
				end
				if (got.mon !== want.mon) begin
					$error("month_index: expected %0d got %0d", want.mon, got.mon);
					errors++;
				end
				if (got.mday !== want.mday) begin
					$error("day_of_month: expected %0d got %0d", want.mday, got.mday);
					errors++;
				end
				if (got.hour !== want.hour) begin
					$error("hour_of_day: expected %0d got %0d", want.hour, got.hour);
					errors++;
				end
				if (got.min !== want.min) begin
					$error("minute_of_hour: expected %0d got %0d", want.min, got.min);
					errors++;
				end
				if (got.sec !== want.sec) begin
					$error("second_of_minute: expected %0d got %0d", want.sec, got.sec);
					errors++;
				end
				if (got.pad !== want.pad) begin
					$error("tdata pad: expected %0d got %0d", want.pad, got.pad);
					errors++;
				end
				if (got.oor !== want.oor) begin
					$error("out_of_range: expected %0d got %0d", want.oor, got.oor);
					errors++;
				end
			end
			words_out++;
			if (words_out == LONG_HOLD_AT)
				n = LONG_HOLD_CYCLES;
			else if ((words_out / 100) % 3 == 1)
				n = 0;
			else
				n = $urandom_range(0, 4);
			ready_wait <= n;
			m_tready   <= (n == 0);
		end else if (ready_wait > 0) begin
			ready_wait <= ready_wait - 1;
			m_tready   <= (ready_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int sel;
		// field extremes, unit boundaries, leap days, range edge
		add_stamp(32'd0, 1'b0);
		add_stamp(32'd1, 1'b0);
		add_stamp(32'd59, 1'b0);
		add_stamp(32'd60, 1'b0);
		add_stamp(32'd3599, 1'b0);
		add_stamp(32'd3600, 1'b0);
		add_stamp(32'd86399, 1'b0);
		add_stamp(32'd86400, 1'b0);
		add_stamp(32'd31535999, 1'b0);
		add_stamp(32'd68169600, 1'b0);
		add_stamp(32'd94694399, 1'b0);
		add_stamp(32'd94694400, 1'b0);
		add_stamp(32'd951782400, 1'b0);
		add_stamp(32'd951868799, 1'b0);
		add_stamp(32'd951868800, 1'b0);
		add_stamp(32'd3981312000, 1'b0);
		add_stamp(32'h7FFFFFFF, 1'b0);
		add_stamp(32'h80000000, 1'b0);
		add_stamp(32'hAAAAAAAA, 1'b0);
		add_stamp(32'h55555555, 1'b0);
		add_stamp(LAST_VALID_SEC, 1'b0);
		add_stamp(LAST_VALID_SEC + 32'd1, 1'b0);
		add_stamp(32'hFFFFFFFF, 1'b0);
		add_stamp(32'd0, 1'b0);

		for (int i = 0; i < 900; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 65)
				add_stamp($urandom_range(0, LAST_VALID_SEC), i == 0 || i == 500);
			else if (sel < 80)
				add_stamp($urandom, i == 0 || i == 500);
			else if (sel < 95)
				// midnight or last second of a random day
				add_stamp(32'($urandom_range(0, LAST_DAY)) * 32'd86400 +
						(($urandom_range(0, 1) == 1) ? 32'd86399 : 32'd0),
						i == 0 || i == 500);
			else
				add_stamp($urandom_range(LAST_VALID_SEC + 32'd1, 32'hFFFFFFFF),
						i == 0 || i == 500);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (stamp_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (calendar_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
